[sv/lph_pkg.sv]
// ---------------------------------------------------------------------------
// Linear probe hash table package
// Shared types, request codes, status codes and slot marks.
// ---------------------------------------------------------------------------
package lph_pkg;

	localparam int DefSlotCount = 256;

	// Request codes.
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_LOOKUP = 2'd1;
	localparam logic [1:0] REQ_DELETE = 2'd2;

	// Status codes.
	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_UPDATED   = 3'd1;
	localparam logic [2:0] ST_FOUND     = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_DELETED   = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;

	// Slot marks.
	localparam logic [1:0] MARK_EMPTY = 2'd0;
	localparam logic [1:0] MARK_USED  = 2'd1;
	localparam logic [1:0] MARK_TOMB  = 2'd2;

	// One request as it travels from the front part to the back part.
	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] key_handle;
		logic [31:0] key_hash;
		logic [63:0] value_in;
	} req_t;

	// One result item.
	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] value_out;
	} res_t;

endpackage

[sv/lph_fifo.sv]
// ---------------------------------------------------------------------------
// Linear probe hash table queue
// Two-entry register queue between the front part and the back part.
// ---------------------------------------------------------------------------
module lph_fifo import lph_pkg::*; #(
	parameter int Width = 130
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [Width-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [Width-1:0] rd_data,
	output logic             empty
);

	logic [Width-1:0] mem_q [2];
	logic             wp_q;
	logic             rp_q;
	logic [1:0]       cnt_q;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign rd_data = mem_q[rp_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en && !full) wp_q <= ~wp_q;
			if (rd_en && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr_en && !full} - {1'b0, rd_en && !empty};
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (wr_en && !full) mem_q[wp_q] <= wr_data;
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(full && !(rd_en && !empty)) |=> full)
		else $error("full queue lost an entry");
	assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !wr_en) |=> empty)
		else $error("empty queue gained an entry");

endmodule

[sv/lph_engine.sv]
// ---------------------------------------------------------------------------
// Linear probe hash table engine
// Probes the slot store one slot a cycle and carries out the request.
// ---------------------------------------------------------------------------
module lph_engine import lph_pkg::*; #(
	parameter int SlotCount = DefSlotCount
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  req_t req,
	output logic req_take,
	output logic res_valid,
	output res_t res,
	input  logic res_full
);

	localparam int AW = $clog2(SlotCount);
	localparam int CW = AW + 1;
	localparam logic [CW+1:0] Limit = (CW+2)'(SlotCount * 3);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CLEAR = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_PROBE = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	// Slot store.
	logic [1:0]  mark_mem [SlotCount];
	logic [31:0] key_mem  [SlotCount];
	logic [63:0] val_mem  [SlotCount];
	logic [1:0]  mark_rd_q;
	logic [31:0] key_rd_q;
	logic [63:0] val_rd_q;

	logic [2:0]    state_q;
	req_t          req_q;
	logic [AW-1:0] idx_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] used_q;
	logic          tomb_q;
	logic [AW-1:0] tomb_at_q;
	logic [AW-1:0] clr_q;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          mark_we;
	logic [AW-1:0] mark_wa;
	logic [1:0]    mark_wd;
	logic          kv_we;
	logic          v_we;
	logic [AW-1:0] kv_wa;
	logic          hit;
	logic          is_empty;
	logic          cur_tomb;
	logic          tomb_any;
	logic [AW-1:0] fill_at;
	logic          last;
	logic [AW-1:0] idx_nx;
	logic          over;

	assign req_take = state_q == S_IDLE && req_valid;
	assign hit      = mark_rd_q == MARK_USED && key_rd_q == req_q.key_handle;
	assign is_empty = mark_rd_q == MARK_EMPTY;
	assign cur_tomb = mark_rd_q == MARK_TOMB;
	// A tombstone in the slot under test counts as the first one if none came before.
	assign tomb_any = tomb_q || cur_tomb;
	assign fill_at  = tomb_q ? tomb_at_q : idx_q;
	assign last     = n_q == CW'(SlotCount - 1);
	assign idx_nx   = (idx_q == AW'(SlotCount - 1)) ? '0 : idx_q + 1'b1;
	assign over     = {used_q, 2'b00} > Limit;

	// Store read address: home slot on take, next slot while probing.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_nx;
		if (req_take) begin
			rd_en   = 1'b1;
			rd_addr = req.key_hash[AW-1:0];
		end else if (state_q == S_PROBE && !hit && !is_empty && !last) begin
			rd_en = 1'b1;
		end
	end

	// Store writes from the clearing pass and from finished requests.
	always_comb begin
		mark_we = 1'b0;
		mark_wa = idx_q;
		mark_wd = MARK_USED;
		kv_we   = 1'b0;
		v_we    = 1'b0;
		kv_wa   = idx_q;
		if (state_q == S_CLEAR) begin
			mark_we = 1'b1;
			mark_wa = clr_q;
			mark_wd = MARK_EMPTY;
		end else if (state_q == S_PROBE && (hit || is_empty || last)) begin
			unique case (req_q.req_type)
				REQ_INSERT: begin
					if (hit) begin
						v_we = 1'b1;
					end else if (!over && (tomb_any || is_empty)) begin
						mark_we = 1'b1;
						kv_we   = 1'b1;
						v_we    = 1'b1;
						mark_wa = fill_at;
						kv_wa   = fill_at;
					end
				end
				REQ_DELETE: begin
					if (hit) begin
						mark_we = 1'b1;
						mark_wd = MARK_TOMB;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mark_we) mark_mem[mark_wa] <= mark_wd;
		if (kv_we) key_mem[kv_wa] <= req_q.key_handle;
		if (v_we) val_mem[kv_wa] <= req_q.value_in;
		if (rd_en) begin
			mark_rd_q <= mark_mem[rd_addr];
			key_rd_q  <= key_mem[rd_addr];
			val_rd_q  <= val_mem[rd_addr];
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			used_q    <= '0;
			idx_q     <= '0;
			n_q       <= '0;
			tomb_q    <= 1'b0;
			tomb_at_q <= '0;
			res_valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(SlotCount - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						idx_q   <= req.key_hash[AW-1:0];
						n_q     <= '0;
						tomb_q  <= 1'b0;
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_PROBE;
				S_PROBE: begin
					if (hit || is_empty || last) begin
						res.value_out <= '0;
						res.status    <= ST_NOT_FOUND;
						unique case (req_q.req_type)
							REQ_INSERT: begin
								if (hit) res.status <= ST_UPDATED;
								else if (over || !(tomb_any || is_empty)) res.status <= ST_FULL;
								else begin
									res.status <= ST_INSERTED;
									if (!tomb_any) used_q <= used_q + 1'b1;
								end
							end
							REQ_LOOKUP: begin
								if (hit) begin
									res.status    <= ST_FOUND;
									res.value_out <= val_rd_q;
								end
							end
							REQ_DELETE: if (hit) res.status <= ST_DELETED;
							default: ;
						endcase
						state_q <= S_DONE;
					end else begin
						if (cur_tomb && !tomb_q) begin
							tomb_q    <= 1'b1;
							tomb_at_q <= idx_q;
						end
						idx_q <= idx_nx;
						n_q   <= n_q + 1'b1;
					end
				end
				S_DONE: begin
					if (!res_full) begin
						res_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q != S_DONE || res_full) res_valid <= 1'b0;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) req_take |=> state_q == S_READ)
		else $error("request taken but no probe started");
	assert property (@(posedge clk) disable iff (!arst_n) res_valid |-> !res_full)
		else $error("result written into a full queue");
	assert property (@(posedge clk) disable iff (!arst_n) used_q <= CW'(SlotCount))
		else $error("used count exceeds slot count");

endmodule

[sv/linear_probe_hash_table_unit.sv]
// ---------------------------------------------------------------------------
// Linear probe hash table unit
// Open-addressing key/value table with linear probing and tombstones.
// ---------------------------------------------------------------------------
// The engine works on one item at a time and takes the next only once it
// has passed on the result of the last one; it reads one slot of the store
// per cycle while it probes. SlotCount must be a power of two,
// as the home slot is taken from the low bits of the hash. After reset the
// engine clears the slot marks before taking the first item. Two-entry
// queues on both sides let the front and back stall on their own.
module linear_probe_hash_table_unit import lph_pkg::*; #(
	parameter int SlotCount = DefSlotCount
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  req_type,
	input  logic [31:0] key_handle,
	input  logic [31:0] key_hash,
	input  logic [63:0] value_in,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [63:0] value_out
);

	req_t in_req;
	req_t q_req;
	res_t e_res;
	res_t o_res;
	logic q_empty;
	logic take;
	logic e_valid;
	logic r_full;

	assign in_req = '{req_type: req_type, key_handle: key_handle,
		key_hash: key_hash, value_in: value_in};

	// Front queue of accepted items.
	lph_fifo #(.Width($bits(req_t))) u_in (
		.clk(clk), .arst_n(arst_n), .wr_en(push), .wr_data(in_req), .full(full),
		.rd_en(take), .rd_data(q_req), .empty(q_empty)
	);

	// Probe engine.
	lph_engine #(.SlotCount(SlotCount)) u_eng (
		.clk(clk), .arst_n(arst_n), .req_valid(!q_empty), .req(q_req), .req_take(take),
		.res_valid(e_valid), .res(e_res), .res_full(r_full)
	);

	// Result queue.
	lph_fifo #(.Width($bits(res_t))) u_out (
		.clk(clk), .arst_n(arst_n), .wr_en(e_valid), .wr_data(e_res), .full(r_full),
		.rd_en(pop), .rd_data(o_res), .empty(empty)
	);

	assign status    = o_res.status;
	assign value_out = o_res.value_out;

endmodule

[tb/hash_table_checker.sv]
// ---------------------------------------------------------------------------
// Hash table checker
// Watches the request and result queues of the hash table, keeps its own
// copy of the slot store to predict each status and value, and compares.
// ---------------------------------------------------------------------------
module hash_table_checker import lph_pkg::*; #(
	parameter int SlotCount = DefSlotCount
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [1:0]  req_type,
	input  logic [31:0] key_handle,
	input  logic [31:0] key_hash,
	input  logic [63:0] value_in,
	input  logic        empty,
	input  logic        pop,
	input  logic [2:0]  status,
	input  logic [63:0] value_out,
	output int          fail_count,
	output int          pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [1:0]  mark_copy [SlotCount];
	logic [31:0] key_copy [SlotCount];
	logic [63:0] value_copy [SlotCount];
	int          used_slots;
	res_t        expected_results [$];

	// Apply one request to the shadow table and return the answer it gives.
	function automatic res_t apply_request(logic [1:0] op, logic [31:0] key,
			logic [31:0] hash, logic [63:0] val);
		res_t r;
		int idx;
		bit hit, tomb, hole;
		int hit_at, tomb_at, hole_at;
		r.status = ST_NOT_FOUND;
		r.value_out = '0;
		idx = int'(hash % SlotCount);
		hit = 0; tomb = 0; hole = 0;
		hit_at = 0; tomb_at = 0; hole_at = 0;
		// Walk the probe sequence, remembering the first tombstone.
		for (int n = 0; n < SlotCount; n++) begin
			if (mark_copy[idx] == MARK_EMPTY) begin
				hole = 1;
				hole_at = idx;
				break;
			end
			if (mark_copy[idx] == MARK_USED) begin
				if (key_copy[idx] == key) begin
					hit = 1;
					hit_at = idx;
					break;
				end
			end else if (!tomb) begin
				tomb = 1;
				tomb_at = idx;
			end
			idx = (idx + 1) % SlotCount;
		end
		case (op)
			REQ_INSERT: begin
				if (hit) begin
					value_copy[hit_at] = val;
					r.status = ST_UPDATED;
				end else if (used_slots * 4 > SlotCount * 3) begin
					r.status = ST_FULL;
				end else if (tomb) begin
					mark_copy[tomb_at] = MARK_USED;
					key_copy[tomb_at] = key;
					value_copy[tomb_at] = val;
					r.status = ST_INSERTED;
				end else if (hole) begin
					mark_copy[hole_at] = MARK_USED;
					key_copy[hole_at] = key;
					value_copy[hole_at] = val;
					used_slots++;
					r.status = ST_INSERTED;
				end else begin
					r.status = ST_FULL;
				end
			end
			REQ_LOOKUP: begin
				if (hit) begin
					r.status = ST_FOUND;
					r.value_out = value_copy[hit_at];
				end
			end
			REQ_DELETE: begin
				if (hit) begin
					mark_copy[hit_at] = MARK_TOMB;
					r.status = ST_DELETED;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Predict on each accepted item and check each accepted result.
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			for (int i = 0; i < SlotCount; i++) begin
				mark_copy[i] = MARK_EMPTY;
				key_copy[i] = '0;
				value_copy[i] = '0;
			end
			used_slots = 0;
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("Result with no item waiting: status %0d value %h",
							status, value_out);
				end else begin
					want = expected_results.pop_front();
					if (want.status !== status || want.value_out !== value_out) begin
						fail_count++;
						if (fail_count <= 10)
							$display("Mismatch: expected status %0d value %h, got %0d %h",
								want.status, want.value_out, status, value_out);
					end
				end
			end
			if (push && !full)
				expected_results.push_back(
					apply_request(req_type, key_handle, key_hash, value_in));
		end
		pending_count = expected_results.size();
	end

endmodule

[tb/testbench.sv]
// ---------------------------------------------------------------------------
// Hash table testbench
// Drives directed and random requests through the hash table unit with
// bursty input, stalling output and one long output hold-off.
// ---------------------------------------------------------------------------
module testbench import lph_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Slots = DefSlotCount;
	localparam int IdleLimit = 20000;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  req_type;
	logic [31:0] key_handle;
	logic [31:0] key_hash;
	logic [63:0] value_in;
	logic        empty;
	logic        pop;
	logic [2:0]  status;
	logic [63:0] value_out;
	int          fail_count;
	int          pending_count;
	bit          hold_off;
	int          idle_cycles;
	logic [31:0] key_pool [16];

	linear_probe_hash_table_unit #(.SlotCount(Slots)) dut (.*);

	hash_table_checker #(.SlotCount(Slots)) checker_i (.*);

	initial clk = 0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// Offer one item and wait until it is taken.
	task automatic send_request(logic [1:0] op, logic [31:0] key, logic [31:0] hash,
			logic [63:0] val);
		push <= 1;
		req_type <= op;
		key_handle <= key;
		key_hash <= hash;
		value_in <= val;
		do @(posedge clk); while (full);
	endtask

	// Drop push for a random gap after a burst.
	task automatic maybe_gap();
		if ($urandom_range(0, 5) == 0) begin
			push <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Random key, mostly from a small pool so hits and collisions happen.
	function automatic logic [31:0] pick_key();
		if ($urandom_range(0, 9) == 0)
			return $urandom();
		return key_pool[$urandom_range(0, 15)];
	endfunction

	// Receiver stalls on its own pattern, with one long hold-off.
	initial begin
		pop <= 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off)
				pop <= 0;
			else
				pop <= ($urandom_range(0, 3) != 0) || (($urandom() & 32'h300) == 0);
		end
	end

	// Watchdog on cycles where nothing is accepted.
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || hold_off)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] k;
		logic [31:0] h;
		push <= 0;
		req_type <= REQ_INSERT;
		key_handle <= '0;
		key_hash <= '0;
		value_in <= '0;
		hold_off = 0;
		arst_n = 0;
		for (int i = 0; i < 16; i++)
			key_pool[i] = $urandom();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: field extremes, every request, zero key and unknown request.
		send_request(REQ_LOOKUP, 32'd1, 32'd0, '0);
		send_request(REQ_INSERT, 32'd1, 32'd0, '1);
		send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0);
		send_request(REQ_INSERT, 32'd0, 32'd0, 64'h0123_4567_89AB_CDEF);
		send_request(REQ_LOOKUP, 32'd1, 32'd0, '0);
		send_request(REQ_LOOKUP, 32'd0, 32'd0, '0);
		send_request(REQ_INSERT, 32'd1, 32'd0, 64'h5555_5555_5555_5555);
		send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
		send_request(REQ_DELETE, 32'd1, 32'd0, '0);
		send_request(REQ_LOOKUP, 32'd0, 32'd0, '0);
		send_request(REQ_INSERT, 32'd7, 32'd256, 64'hAAAA_AAAA_AAAA_AAAA);
		send_request(REQ_LOOKUP, 32'd7, 32'd0, '0);
		send_request(REQ_DELETE, 32'd1, 32'd0, '0);
		send_request(2'd3, 32'd7, 32'd0, '1);
		send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);

		// Long hold-off while the sender keeps offering items.
		fork
			begin
				hold_off = 1;
				repeat (200) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 20; i++)
				send_request(REQ_INSERT, pick_key(), $urandom(), {$urandom(), $urandom()});
		join

		// Random mix, mostly keys from the pool at one hash each.
		for (int i = 0; i < 250; i++) begin
			k = pick_key();
			h = k * 32'd2654435761;
			case ($urandom_range(0, 9))
				0, 1, 2, 3: send_request(REQ_INSERT, k, h, {$urandom(), $urandom()});
				4, 5, 6: send_request(REQ_LOOKUP, k, h, {$urandom(), $urandom()});
				7, 8: send_request(REQ_DELETE, k, h, {$urandom(), $urandom()});
				default: send_request(2'($urandom()), k, h, {$urandom(), $urandom()});
			endcase
			maybe_gap();
		end

		// Fill past the load limit with fresh keys, clustered hashes.
		for (int i = 0; i < 220; i++) begin
			k = $urandom();
			h = $urandom_range(0, 40) + ($urandom() & 32'hFFFF_FF00);
			case ($urandom_range(0, 7))
				0: send_request(REQ_DELETE, pick_key(), $urandom(), '0);
				1: send_request(REQ_LOOKUP, k, h, '0);
				default: send_request(REQ_INSERT, k, h, {$urandom(), $urandom()});
			endcase
			maybe_gap();
		end
		push <= 0;

		// Drain, then let the engine settle.
		while (pending_count != 0) @(posedge clk);
		repeat (Slots + 20) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
